@@ design/egm_pkg.sv @@
package egm_pkg;

	// input op codes carried in tuser
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// widest cell address over the legal grid sizes
	localparam int ADDR_W = 18;

	// Q.14 fraction bits
	localparam int FRAC_W = 14;

	// rotation rows, Q1.14
	localparam logic signed [15:0] ROT [3][3] = '{
		'{16'sd16376, 16'sd220,   -16'sd447},
		'{-16'sd498,  16'sd8389,  -16'sd14064},
		'{16'sd41,    16'sd14072, 16'sd8392}
	};

	// translation, millimetres Q.14
	localparam logic signed [24:0] TRN [3] = '{25'sd367002, 25'sd3941990, 25'sd9392947};

	// command classes passed from front to back
	typedef enum logic [2:0] {
		KIND_ZERO,
		KIND_ADD,
		KIND_READ,
		KIND_ECHO,
		KIND_CLEAR
	} egm_kind_t;

	typedef struct packed {
		egm_kind_t          kind;
		logic [6:0]         row;
		logic [6:0]         col;
		logic [ADDR_W-1:0]  addr;
		logic signed [15:0] height;
	} egm_cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_ROUND,
		ST_OUT
	} egm_state_t;

endpackage

@@ design/point_to_elevation_grid_mean_top.sv @@
// Elevation grid binning with per-cell mean height.
// Input beats arrive on s_axis: tuser carries the op (add point, read cell,
// clear grid), tdata the sensor point and the cell to read. Each input beat
// gives exactly one result beat on m_axis with in-range flag, cell indices,
// mean height and point count.
// A front pipeline of five stages transforms the point into robot
// coordinates and bins it; a four-entry queue feeds the back end, which
// does the read-modify-write of the cell store and a bit-serial mean divide.
// An add or a non-empty read passes the five front stages, the queue,
// one store read, one update, the 34 divider steps and rounding.
// An empty-cell read skips divide and rounding; out of grid, echo and
// unused op go straight to the result. The back end handles one item at a
// time, so the 34-step divider sets the rate of adds; a clear op sweeps the
// whole store, one cell a cycle, before its result.
// After reset the store is swept to zero the same way; beats queue up in
// the front meanwhile and then stall.
// When m_axis_tready is low the result holds, the queue fills, and the
// front then deasserts s_axis_tready.
module point_to_elevation_grid_mean_top import egm_pkg::*; #(
	parameter int GRID_ROWS  = 120,
	parameter int GRID_COLS  = 120,
	parameter int CELL_MM    = 25,
	parameter int COL_OFFSET = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,  // op
	input  logic [55:0] s_axis_tdata,  // x_mm, y_mm, z_mm, cell_row, cell_col
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // in_range, row_index, col_index, mean_height_mm, point_count
);

	logic     f_valid, f_ready, b_valid, b_ready;
	egm_cmd_t f_cmd, b_cmd;

	// point transform and binning
	egm_front #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS),
		.CELL_MM   (CELL_MM),
		.COL_OFFSET(COL_OFFSET)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tdata (s_axis_tdata),
		.cmd_valid    (f_valid),
		.cmd_ready    (f_ready),
		.cmd          (f_cmd)
	);

	// decoupling queue
	egm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_cmd),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_cmd)
	);

	// cell store and mean
	egm_back #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (b_valid),
		.cmd_ready    (b_ready),
		.cmd          (b_cmd),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

@@ design/egm_front.sv @@
module egm_front import egm_pkg::*; #(
	parameter int GRID_ROWS  = 120,
	parameter int GRID_COLS  = 120,
	parameter int CELL_MM    = 25,
	parameter int COL_OFFSET = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,  // op
	input  logic [55:0] s_axis_tdata,  // x_mm, y_mm, z_mm, cell_row, cell_col
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output egm_cmd_t    cmd
);

	localparam int  AW    = $clog2(GRID_ROWS * GRID_COLS);
	localparam int  RI    = $clog2(GRID_ROWS);
	localparam int  CI    = $clog2(GRID_COLS);
	localparam longint LAT = longint'(COL_OFFSET) * CELL_MM * (64'd1 << FRAC_W);
	localparam longint FWD = longint'(GRID_ROWS) * CELL_MM * (64'd1 << FRAC_W);
	localparam logic signed [47:0] LAT_B = 48'(LAT);
	localparam logic signed [47:0] FWD_B = 48'(FWD);
	// reciprocal of the cell size, exact for quotients of 20-bit values
	localparam longint RECIP = ((64'd1 << 32) + CELL_MM - 1) / CELL_MM;
	localparam logic [32:0] RECIP_B = 33'(RECIP);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [1:0]         op_s1, op_s2, op_s3, op_s4, op_s5;
	logic signed [13:0] x_s1, y_s1, z_s1;
	logic [6:0]         crow_s1, crow_s2, crow_s3, crow_s4, crow_s5;
	logic [6:0]         ccol_s1, ccol_s2, ccol_s3, ccol_s4, ccol_s5;
	logic signed [30:0] prod_s2 [3][3];
	logic signed [29:0] q_s3 [3];
	logic               inb_s4, inb_s5;
	logic [19:0]        m0_s4, m2_s4;
	logic signed [15:0] h_s4, h_s5;
	logic [20:0]        col_s5, row_s5;

	logic signed [14:0] p [3];
	logic signed [47:0] q0_w, q2_w, n0_w;
	logic signed [29:0] h_rnd;
	logic [52:0]        prod0, prod2;
	logic               grid_ok;
	logic [RI-1:0]      sel_row;
	logic [CI-1:0]      sel_col;
	logic [AW-1:0]      addr_w;

	// whole pipeline holds while the last stage waits on the queue
	assign en            = !v_s5 || cmd_ready;
	assign s_axis_tready = en;
	assign cmd_valid     = v_s5;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// mirrored sensor point
	always_comb begin
		p[0] = -15'(x_s1);
		p[1] = -15'(y_s1);
		p[2] = 15'(z_s1);
	end

	// bounds, bin numerators and rounded height
	always_comb begin
		q0_w  = 48'(q_s3[0]);
		q2_w  = 48'(q_s3[2]);
		n0_w  = q0_w + LAT_B;
		h_rnd = (q_s3[1] + 30'sd8192) >>> FRAC_W;
	end

	// bin by reciprocal multiply
	always_comb begin
		prod0 = 53'(m0_s4) * 53'(RECIP_B);
		prod2 = 53'(m2_s4) * 53'(RECIP_B);
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= s_axis_tuser;
			x_s1    <= s_axis_tdata[13:0];
			y_s1    <= s_axis_tdata[27:14];
			z_s1    <= s_axis_tdata[41:28];
			crow_s1 <= s_axis_tdata[48:42];
			ccol_s1 <= s_axis_tdata[55:49];

			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= 31'(ROT[i][j]) * 31'(p[j]);
				end
			end
			op_s2   <= op_s1;
			crow_s2 <= crow_s1;
			ccol_s2 <= ccol_s1;

			for (int i = 0; i < 3; i++) begin
				q_s3[i] <= 30'(prod_s2[i][0]) + 30'(prod_s2[i][1]) + 30'(prod_s2[i][2])
					+ 30'(TRN[i]);
			end
			op_s3   <= op_s2;
			crow_s3 <= crow_s2;
			ccol_s3 <= ccol_s2;

			inb_s4  <= (q0_w > -LAT_B) && (q0_w < LAT_B) && (q2_w > 48'sd0) && (q2_w < FWD_B);
			m0_s4   <= n0_w[33:14];
			m2_s4   <= q2_w[33:14];
			h_s4    <= 16'(h_rnd);
			op_s4   <= op_s3;
			crow_s4 <= crow_s3;
			ccol_s4 <= ccol_s3;

			col_s5  <= prod0[52:32];
			row_s5  <= prod2[52:32];
			inb_s5  <= inb_s4;
			h_s5    <= h_s4;
			op_s5   <= op_s4;
			crow_s5 <= crow_s4;
			ccol_s5 <= ccol_s4;
		end
	end

	// classify and form the cell address
	always_comb begin
		grid_ok = 1'b0;
		sel_row = '0;
		sel_col = '0;
		cmd     = '0;
		cmd.height = h_s5;
		unique case (op_s5)
			OP_ADD: begin
				grid_ok = inb_s5 && (row_s5 < 21'(GRID_ROWS)) && (col_s5 < 21'(GRID_COLS));
				sel_row = row_s5[RI-1:0];
				sel_col = col_s5[CI-1:0];
				if (grid_ok) begin
					cmd.kind = KIND_ADD;
					cmd.row  = row_s5[6:0];
					cmd.col  = col_s5[6:0];
				end else begin
					cmd.kind = KIND_ZERO;
				end
			end
			OP_READ: begin
				grid_ok  = (32'(crow_s5) < GRID_ROWS) && (32'(ccol_s5) < GRID_COLS);
				sel_row  = RI'(crow_s5);
				sel_col  = CI'(ccol_s5);
				cmd.kind = grid_ok ? KIND_READ : KIND_ECHO;
				cmd.row  = crow_s5;
				cmd.col  = ccol_s5;
			end
			OP_CLEAR: cmd.kind = KIND_CLEAR;
			default:  cmd.kind = KIND_ZERO;
		endcase
		addr_w   = AW'(sel_row) * AW'(GRID_COLS) + AW'(sel_col);
		cmd.addr = ADDR_W'(addr_w);
	end

endmodule

@@ design/egm_queue.sv @@
module egm_queue import egm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  egm_cmd_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output egm_cmd_t pop_data
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	egm_cmd_t      slot_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign push_ready = (cnt_q != (PW+1)'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_data;
	end

endmodule

@@ design/egm_back.sv @@
module egm_back import egm_pkg::*; #(
	parameter int GRID_ROWS = 120,
	parameter int GRID_COLS = 120
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  egm_cmd_t    cmd,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata  // in_range, row_index, col_index, mean_height_mm, point_count
);

	localparam int CELLS = GRID_ROWS * GRID_COLS;
	localparam int AW    = $clog2(CELLS);

	// cell store: 16-bit count in the upper bits, 32-bit height sum in the lower
	logic [47:0] mem [CELLS];

	egm_state_t state_q, state_d;
	logic [AW-1:0] clr_addr_q;
	logic          clr_emit_q;
	egm_cmd_t      cmd_q;
	logic [47:0]   rd_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [47:0]        mem_wdata;

	logic [33:0]        mag_q;
	logic [33:0]        quo_q;
	logic [17:0]        rem_q;
	logic [16:0]        den_q;
	logic               neg_q;
	logic [5:0]         step_q;

	logic               res_inr_q;
	logic [6:0]         res_row_q, res_col_q;
	logic signed [13:0] res_mean_q;
	logic [15:0]        res_cnt_q;

	logic signed [31:0] old_sum, new_sum;
	logic [15:0]        old_cnt, new_cnt;
	logic               do_add;
	logic signed [33:0] num;
	logic [17:0]        rem_sh, rem_nx;
	logic               qbit;
	logic [34:0]        qfix;
	logic signed [13:0] mean_w;

	assign cmd_ready     = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {3'b000, res_cnt_q, res_mean_q, res_col_q, res_row_q, res_inr_q};

	// cell update
	always_comb begin
		old_sum = rd_q[31:0];
		old_cnt = rd_q[47:32];
		do_add  = (cmd_q.kind == KIND_ADD) && (old_cnt != 16'hFFFF);
		new_sum = do_add ? old_sum + 32'(cmd_q.height) : old_sum;
		new_cnt = do_add ? old_cnt + 16'd1 : old_cnt;
		num     = 34'(new_sum) * 34'sd2 + 34'(new_cnt);
	end

	// one restoring division step
	always_comb begin
		rem_sh = {rem_q[16:0], mag_q[33]};
		qbit   = (rem_sh >= 18'(den_q));
		rem_nx = qbit ? rem_sh - 18'(den_q) : rem_sh;
	end

	// floor of the signed quotient, saturated
	always_comb begin
		qfix = 35'(quo_q) + 35'(neg_q && (rem_q != '0));
		if (neg_q) begin
			mean_w = (qfix > 35'd8192) ? -14'sd8192 : 14'(-qfix);
		end else begin
			mean_w = (qfix > 35'd8191) ? 14'sd8191 : 14'(qfix);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(CELLS - 1)) state_d = clr_emit_q ? ST_OUT : ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						KIND_ADD, KIND_READ: state_d = ST_UPDATE;
						KIND_CLEAR:          state_d = ST_CLEAR;
						default:             state_d = ST_OUT;
					endcase
				end
			end
			ST_UPDATE: state_d = (new_cnt == '0) ? ST_OUT : ST_DIVIDE;
			ST_DIVIDE: if (step_q == 6'd33) state_d = ST_ROUND;
			ST_ROUND:  state_d = ST_OUT;
			ST_OUT:    if (m_axis_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// store write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cmd_q.addr[AW-1:0];
		mem_wdata = {new_cnt, new_sum};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
			end
			ST_UPDATE: mem_we = do_add;
			default:   mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			clr_emit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= (clr_addr_q == AW'(CELLS - 1)) ? '0 : clr_addr_q + 1'b1;
			end
			if (state_q == ST_IDLE && cmd_valid) clr_emit_q <= 1'b1;
		end
	end

	// memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (state_q == ST_IDLE && cmd_valid) rd_q <= mem[cmd.addr[AW-1:0]];
	end

	// command, divider and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q      <= cmd;
				res_inr_q  <= 1'b0;
				res_row_q  <= (cmd.kind == KIND_ECHO) ? cmd.row : 7'd0;
				res_col_q  <= (cmd.kind == KIND_ECHO) ? cmd.col : 7'd0;
				res_mean_q <= '0;
				res_cnt_q  <= '0;
			end
			ST_UPDATE: begin
				res_inr_q  <= (cmd_q.kind == KIND_ADD);
				res_row_q  <= cmd_q.row;
				res_col_q  <= cmd_q.col;
				res_cnt_q  <= new_cnt;
				res_mean_q <= '0;
				neg_q      <= num[33];
				mag_q      <= num[33] ? 34'(-num) : 34'(num);
				den_q      <= {new_cnt, 1'b0};
				rem_q      <= '0;
				quo_q      <= '0;
				step_q     <= '0;
			end
			ST_DIVIDE: begin
				rem_q  <= rem_nx;
				quo_q  <= {quo_q[32:0], qbit};
				mag_q  <= {mag_q[32:0], 1'b0};
				step_q <= step_q + 6'd1;
			end
			ST_ROUND: res_mean_q <= mean_w;
			default: begin
				res_inr_q <= res_inr_q;
			end
		endcase
	end

endmodule

@@ tb/sv/egm_checker.sv @@
// watches both channels, predicts each result beat and compares it
module egm_checker import egm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,
	input  logic [55:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	output int          fail_count,
	output int          results_owed,
	output int          adds_in_grid,
	output int          reads_seen
);

	localparam int ROWS   = 120;
	localparam int COLS   = 120;
	localparam int CELL   = 25;
	localparam int COLOFS = 60;
	localparam longint ONE_Q = 64'sd16384;

	// mirror of the cell store
	int height_acc [ROWS*COLS];
	int hit_count  [ROWS*COLS];

	// predicted result beats, oldest first
	logic [47:0] result_fifo [$];

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic longint mean_of(longint total, longint n);
		longint m;
		if (n == 0)
			return 0;
		m = floor_quot(2 * total + n, 2 * n);
		if (m > 8191) m = 8191;
		if (m < -8192) m = -8192;
		return m;
	endfunction

	function automatic logic [47:0] pack_result(logic inr, logic [6:0] r, logic [6:0] c,
			longint mean, int n);
		logic [13:0] m14;
		logic [15:0] n16;
		m14 = mean[13:0];
		n16 = n[15:0];
		return {3'b0, n16, m14, c, r, inr};
	endfunction

	// bin a point, read a cell or clear the grid, updating the mirror store
	function automatic logic [47:0] grid_predict(logic [1:0] op, logic [55:0] d);
		longint px, py, pz, qx, qy, qz, lat, fwd, cw, row, col, h;
		int k;
		logic [6:0] r, c;
		lat = longint'(COLOFS) * CELL * ONE_Q;
		fwd = longint'(ROWS) * CELL * ONE_Q;
		cw  = longint'(CELL) * ONE_Q;
		case (op)
			OP_ADD: begin
				px = -longint'($signed(d[13:0]));
				py = -longint'($signed(d[27:14]));
				pz = longint'($signed(d[41:28]));
				qx = ROT[0][0] * px + ROT[0][1] * py + ROT[0][2] * pz + TRN[0];
				qy = ROT[1][0] * px + ROT[1][1] * py + ROT[1][2] * pz + TRN[1];
				qz = ROT[2][0] * px + ROT[2][1] * py + ROT[2][2] * pz + TRN[2];
				if (!(qx > -lat && qx < lat && qz > 0 && qz < fwd))
					return '0;
				row = floor_quot(qz, cw);
				col = floor_quot(qx, cw) + COLOFS;
				if (row < 0 || row >= ROWS || col < 0 || col >= COLS)
					return '0;
				k = int'(row) * COLS + int'(col);
				h = floor_quot(qy + ONE_Q / 2, ONE_Q);
				if (hit_count[k] != 65535) begin
					height_acc[k] = height_acc[k] + int'(h);
					hit_count[k]  = hit_count[k] + 1;
				end
				adds_in_grid++;
				return pack_result(1'b1, row[6:0], col[6:0],
					mean_of(height_acc[k], hit_count[k]), hit_count[k]);
			end
			OP_READ: begin
				r = d[48:42];
				c = d[55:49];
				reads_seen++;
				if (r >= ROWS || c >= COLS)
					return pack_result(1'b0, r, c, 0, 0);
				k = int'(r) * COLS + int'(c);
				return pack_result(1'b0, r, c, mean_of(height_acc[k], hit_count[k]),
					hit_count[k]);
			end
			OP_CLEAR: begin
				foreach (height_acc[i]) begin
					height_acc[i] = 0;
					hit_count[i]  = 0;
				end
				return '0;
			end
			default: return '0;
		endcase
	endfunction

	initial begin
		fail_count   = 0;
		results_owed = 0;
		adds_in_grid = 0;
		reads_seen   = 0;
		foreach (height_acc[i]) begin
			height_acc[i] = 0;
			hit_count[i]  = 0;
		end
	end

	// predict on each accepted input beat, compare each accepted result beat
	always @(posedge clk) begin
		logic [47:0] want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				result_fifo.push_back(grid_predict(s_axis_tuser, s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_fifo.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("checker: unexpected result beat %h", m_axis_tdata);
				end else begin
					want = result_fifo.pop_front();
					if (want[0] !== m_axis_tdata[0] || want[7:1] !== m_axis_tdata[7:1] ||
							want[14:8] !== m_axis_tdata[14:8] ||
							want[28:15] !== m_axis_tdata[28:15] ||
							want[44:29] !== m_axis_tdata[44:29]) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("checker: mismatch inr %0d/%0d row %0d/%0d",
								want[0], m_axis_tdata[0], want[7:1], m_axis_tdata[7:1]);
							$write(" col %0d/%0d", want[14:8], m_axis_tdata[14:8]);
							$display(" mean %0d/%0d cnt %0d/%0d (exp/got)",
								$signed(want[28:15]), $signed(m_axis_tdata[28:15]),
								want[44:29], m_axis_tdata[44:29]);
						end
					end
				end
			end
			results_owed = result_fifo.size();
		end
	end

endmodule

@@ tb/sv/tb.sv @@
module tb;
	import egm_pkg::*;

	localparam int STALL_LIMIT = 60000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [1:0]  s_axis_tuser;   // op
	logic [55:0] s_axis_tdata;   // x_mm, y_mm, z_mm, cell_row, cell_col
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // in_range, row_index, col_index, mean_height_mm, point_count

	int  fail_count, results_owed, adds_in_grid, reads_seen;
	int  quiet_cycles;
	bit  gaps_on;
	bit  long_hold;
	int  beats_sent;
	logic [6:0] last_row, last_col;

	point_to_elevation_grid_mean_top dut (.*);

	egm_checker chk (.*);

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// sender: one beat, with an optional random gap first
	task automatic send_beat(logic [1:0] op, logic [13:0] x, logic [13:0] y, logic [13:0] z,
			logic [6:0] r, logic [6:0] c);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {c, r, z, y, x};
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
	endtask

	task automatic read_cell(logic [6:0] r, logic [6:0] c);
		send_beat(OP_READ, 14'($urandom), 14'($urandom), 14'($urandom), r, c);
	endtask

	task automatic add_point(int x, int y, int z);
		send_beat(OP_ADD, 14'(x), 14'(y), 14'(z), 7'($urandom), 7'($urandom));
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (results_owed == 0);
		repeat (60) @(posedge clk);
	endtask

	// receiver: random stall bursts plus one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (500) @(posedge clk);
				long_hold = 0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else
				m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("tb: no progress for %0d cycles, %0d results owed", quiet_cycles,
				results_owed);
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		int kind, px, py, pz;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = '0;
		s_axis_tdata  = '0;
		gaps_on       = 0;
		long_hold     = 0;
		beats_sent    = 0;
		last_row      = 22;
		last_col      = 60;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners, out-of-grid extremes, repeated cell, unused op, clear
		read_cell(0, 0);
		read_cell(119, 119);
		read_cell(127, 127);
		read_cell(119, 0);
		add_point(0, 0, 0);
		add_point(0, 0, 0);
		add_point(10, -30, 5);
		read_cell(22, 60);
		add_point(-8192, -8192, -8192);
		add_point(8191, 8191, 8191);
		add_point(-8192, 8191, 8191);
		add_point(8191, -8192, 0);
		add_point(1400, 0, 1000);
		add_point(-1400, 0, 1000);
		add_point(0, -2000, 3000);
		add_point(0, 500, -800);
		send_beat(OP_NONE, 14'h3fff, 14'h3fff, 14'h3fff, 7'h7f, 7'h7f);
		read_cell(22, 60);
		send_beat(OP_CLEAR, '0, '0, '0, '0, '0);
		read_cell(22, 60);
		add_point(0, 0, 0);
		read_cell(22, 60);
		drain();

		// random traffic with gaps on both sides
		gaps_on = 1;
		px = 0; py = 0; pz = 0;
		for (int n = 0; n < 400; n++) begin
			if (n == 120)
				long_hold = 1;
			if (n == 200 || n == 330)
				drain();
			if (n == 360)
				gaps_on = 0;
			kind = $urandom_range(0, 99);
			if (kind < 2 && n > 50 && n < 300)
				send_beat(OP_CLEAR, 14'($urandom), 14'($urandom), 14'($urandom),
					7'($urandom), 7'($urandom));
			else if (kind < 4)
				send_beat(OP_NONE, 14'($urandom), 14'($urandom), 14'($urandom),
					7'($urandom), 7'($urandom));
			else if (kind < 14)
				send_beat(OP_ADD, 14'($urandom), 14'($urandom), 14'($urandom),
					7'($urandom), 7'($urandom));
			else if (kind < 22)
				read_cell(last_row, last_col);
			else if (kind < 27)
				read_cell(7'($urandom), 7'($urandom));
			else begin
				// mostly in-grid points, often near the previous one to stack cells
				if ($urandom_range(0, 2) != 0) begin
					px = $urandom_range(0, 3200) - 1600;
					py = $urandom_range(0, 4000) - 2000;
					pz = $urandom_range(0, 6000) - 2000;
				end else begin
					px = px + $urandom_range(0, 10) - 5;
					py = py + $urandom_range(0, 10) - 5;
				end
				add_point(px, py, pz);
			end
			if (m_axis_tvalid && m_axis_tdata[0]) begin
				last_row = m_axis_tdata[7:1];
				last_col = m_axis_tdata[14:8];
			end
		end
		drain();
		repeat (100) @(posedge clk);

		$display("tb: %0d beats sent, %0d points binned in grid, %0d cell reads",
			beats_sent, adds_in_grid, reads_seen);
		$display("tb: covered clears, unused op, long output stall and random gaps");
		if (fail_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
